// File: design/sffc_pkg.sv
`timescale 1ns / 1ps
// Package for the small float format converter.
// Holds operation codes and the per-format conversion functions; no dependencies.
package sffc_pkg;

	typedef enum logic [2:0] {
		FUNC_H2S = 3'd0,
		FUNC_S2H = 3'd1,
		FUNC_BF2S = 3'd2,
		FUNC_S2BF = 3'd3,
		FUNC_E2H = 3'd4,
		FUNC_H2E = 3'd5,
		FUNC_H2E_SAT = 3'd6,
		FUNC_NONE = 3'd7
	} func_t;

	function automatic logic [31:0] h_to_s(input logic [15:0] h);
		logic [31:0] sign;
		logic [14:0] mag;
		logic [3:0] lz;
		logic [9:0] m;
		logic [7:0] e;
		sign = {h[15], 31'd0};
		mag = h[14:0];
		lz = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (mag[i] && lz == 4'd0) lz = 4'(10 - i);
		end
		m = 10'(mag[9:0] << lz);
		e = 8'(8'd113 - 8'(lz));
		if (mag >= 15'h7C00) return sign | 32'h7F800000 | {9'd0, mag[9:0], 13'd0};
		if (mag >= 15'h0400) return sign | ({4'd0, mag, 13'd0} + 32'h38000000);
		if (mag == 15'd0) return sign;
		return sign | {1'b0, e, m, 13'd0};
	endfunction

	function automatic logic [15:0] s_to_h(input logic [31:0] s);
		logic [15:0] sign;
		logic [30:0] mag;
		logic [7:0] e;
		logic [31:0] v;
		logic [23:0] sig;
		logic [4:0] sh;
		logic [23:0] q;
		logic [23:0] msk;
		logic [23:0] rem;
		logic [23:0] half;
		sign = {s[31], 15'd0};
		mag = s[30:0];
		e = mag[30:23];
		v = {1'b0, mag} - 32'h38000000;
		v = v + {31'd0, v[13]};
		v = v + 32'hFFF;
		v = v >> 13;
		if (v > 32'h7C00) v = 32'h7C00;
		sig = {1'b1, mag[22:0]};
		sh = 5'(8'd126 - e);
		q = sig >> sh;
		msk = (24'd1 << sh) - 24'd1;
		rem = sig & msk;
		half = 24'd1 << (sh - 5'd1);
		if (rem > half || (rem == half && q[0])) q = q + 24'd1;
		if (mag > 31'h7F800000) return sign | 16'h7E00;
		if (e >= 8'd113) return sign | v[15:0];
		if (e == 8'd0 || e < 8'd102) return sign;
		return sign | q[15:0];
	endfunction

	function automatic logic [15:0] s_to_bf(input logic [31:0] s);
		logic nan;
		logic [31:0] u;
		logic [15:0] b;
		nan = s[30:0] > 31'h7F800000;
		u = s + 32'd32767 + ((s[16:0] == 17'h18000) ? 32'h10000 : 32'd0);
		b = u[31:16];
		if (b[14:0] == 15'h7F80 && nan) return b + 16'h40;
		if (b[14:0] == 15'd0 && nan) return b - 16'd1;
		return b;
	endfunction

	function automatic logic [15:0] round_low_byte(input logic [15:0] h);
		return h + 16'h80 - ((h[8:0] == 9'h080) ? 16'd1 : 16'd0);
	endfunction

	function automatic logic [7:0] h_to_e5m2(input logic [15:0] h, input logic sat);
		logic [15:0] r;
		if (sat) begin
			if (h[14:0] >= 15'h7B80) r = (h - 16'd1) | 16'h0300;
			else r = round_low_byte(h);
		end else if (h[14:10] == 5'h1F) begin
			r = (h[7:0] != 8'd0) ? (h | 16'h7F00) : h;
		end else begin
			r = round_low_byte(h);
		end
		return r[15:8];
	endfunction

endpackage

// File: design/sffc_core.sv
`timescale 1ns / 1ps
// Combinational conversion datapath of the small float format converter.
// Depends on sffc_pkg.
module sffc_core (
	input logic [2:0] func,
	input logic [31:0] operand,
	output logic [31:0] converted
);
	always_comb begin
		unique case (sffc_pkg::func_t'(func))
			sffc_pkg::FUNC_H2S: converted = sffc_pkg::h_to_s(operand[15:0]);
			sffc_pkg::FUNC_S2H: converted = {16'd0, sffc_pkg::s_to_h(operand)};
			sffc_pkg::FUNC_BF2S: converted = {operand[15:0], 16'd0};
			sffc_pkg::FUNC_S2BF: converted = {16'd0, sffc_pkg::s_to_bf(operand)};
			sffc_pkg::FUNC_E2H: converted = {16'd0, operand[7:0], 8'd0};
			sffc_pkg::FUNC_H2E: converted = {24'd0, sffc_pkg::h_to_e5m2(operand[15:0], 1'b0)};
			sffc_pkg::FUNC_H2E_SAT:
				converted = {24'd0, sffc_pkg::h_to_e5m2(operand[15:0], 1'b1)};
			default: converted = 32'd0;
		endcase
	end
endmodule

// File: design/small_float_format_converter_unit.sv
`timescale 1ns / 1ps
// Top level of the small float format converter: input register, datapath, result register.
// Depends on sffc_pkg and sffc_core.
// One request per clock while m_axis_tready does not stall the output; a request passes
// through the input register, one combinational pass and the result register.
module small_float_format_converter_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // func[2:0], operand[34:3], zero pad
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata // converted[31:0]
);
	logic v_s1;
	logic [2:0] func_s1;
	logic [31:0] op_s1;
	logic [31:0] conv;
	logic adv_s1;
	logic adv_out;

	assign adv_out = !m_axis_tvalid || m_axis_tready;
	assign adv_s1 = !v_s1 || adv_out;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			func_s1 <= s_axis_tdata[2:0];
			op_s1 <= s_axis_tdata[34:3];
		end
	end

	sffc_core u_core (
		.func(func_s1),
		.operand(op_s1),
		.converted(conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_out) begin
			m_axis_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			m_axis_tdata <= conv;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_out |=> m_axis_tvalid)
		else $error("stage request lost");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && m_axis_tvalid)
		else $error("ready low without full pipeline");
endmodule
